@@ hdl/adsf_pkg.sv @@
// Shared constants, codes and types for the ADC deadband smoothing filter.
package adsf_pkg;

  localparam int CHANNELS    = 6;
  localparam int CHAN_W      = 3;
  localparam int SAMPLE_BITS = 12;
  localparam int K_W         = 8;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 3;
  // prev*k + sample needs one bit more than the product
  localparam int NUM_W       = SAMPLE_BITS + K_W + 1;
  localparam int DIV_W       = K_W + 1;
  localparam int CNT_W       = $clog2(NUM_W + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_EN = 3'd0,
    CFG_SMOOTH    = 3'd1,
    CFG_DEADBAND  = 3'd2,
    CFG_STEP      = 3'd3,
    CFG_LIMIT_EN  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_LIMIT,
    ST_WRITE
  } state_t;

endpackage

@@ hdl/adc_deadband_smoothing_filter_unit.sv @@
// Top level: per-channel deadband, smoothing and step limit over a channel memory.
//
//  port group   dir   handshake          payload
//  in_          in    in_valid/in_ready  in_channel, in_raw_sample
//  out_         out   out_valid/out_ready out_channel, out_filtered_value
//  cfg_         in    cfg_we             cfg_index, cfg_wdata
//
// A filtered word passes read, multiply-add, divider, limit and write on its way to the
// output register; a pass-through word skips the divider and limit.
// A word for a channel beyond the last is dropped in the cycle it is taken.
// Synchronous reset clears the seen flags and restores register defaults.
// The output register frees the input side: a new word is taken while a result waits;
// a second result holds in the write state until the output register drains.
module adc_deadband_smoothing_filter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [adsf_pkg::CHAN_W-1:0]         in_channel,
  input  logic [adsf_pkg::SAMPLE_BITS-1:0]    in_raw_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [adsf_pkg::CHAN_W-1:0]         out_channel,
  output logic [adsf_pkg::SAMPLE_BITS-1:0]    out_filtered_value,
  input  logic                                cfg_we,
  input  logic [adsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [adsf_pkg::CFG_W-1:0]          cfg_wdata
);
  import adsf_pkg::*;

  // configuration
  logic                   filter_en_r;
  logic [K_W-1:0]         smooth_r;
  logic [SAMPLE_BITS-1:0] deadband_r;
  logic [SAMPLE_BITS-1:0] step_r;
  logic                   limit_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r <= 1'b1;
      smooth_r    <= K_W'(10);
      deadband_r  <= SAMPLE_BITS'(12);
      step_r      <= SAMPLE_BITS'(20);
      limit_en_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FILTER_EN: filter_en_r <= cfg_wdata[0];
        CFG_SMOOTH:    smooth_r    <= cfg_wdata[K_W-1:0];
        CFG_DEADBAND:  deadband_r  <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_STEP:      step_r      <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_LIMIT_EN:  limit_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // control and datapath registers
  state_t                 state_r, state_nxt;
  logic [CHANNELS-1:0]    seen_r, seen_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0]      out_chan_r, out_chan_nxt;
  logic [SAMPLE_BITS-1:0] out_val_r, out_val_nxt;
  logic [CHAN_W-1:0]      ch_r, ch_nxt;
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [SAMPLE_BITS-1:0] res_r, res_nxt;
  logic [SAMPLE_BITS-1:0] prev_r;

  logic [SAMPLE_BITS-1:0] mem [CHANNELS];

  logic                   in_acc, in_range, mem_we, div_start, div_done, out_go;
  logic [SAMPLE_BITS-1:0] div_q, diff, dead_sample;
  logic [NUM_W-1:0]       numer;
  logic [SAMPLE_BITS:0]   hi_bound, lo_test;

  assign in_acc   = in_valid && in_ready;
  assign in_range = ({1'b0, in_channel} < (CHAN_W + 1)'(CHANNELS));
  assign out_go   = !out_valid_r || out_ready;

  // deadband then prev*k + sample
  assign diff        = (sample_r > prev_r) ? sample_r - prev_r : prev_r - sample_r;
  assign dead_sample = (diff < deadband_r) ? prev_r : sample_r;
  assign numer       = NUM_W'(prev_r) * NUM_W'(smooth_r) + NUM_W'(dead_sample);

  assign hi_bound = {1'b0, prev_r} + {1'b0, step_r};
  assign lo_test  = {1'b0, res_r} + {1'b0, step_r};

  adsf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (numer),
    .divisor  ({1'b0, smooth_r} + DIV_W'(1)),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_chan_nxt  = out_chan_r;
    out_val_nxt   = out_val_r;
    ch_nxt        = ch_r;
    sample_nxt    = sample_r;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    div_start     = 1'b0;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ch_nxt     = in_channel;
          sample_nxt = in_raw_sample;
          // drop words for channels that do not exist
          if (in_range) state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (!seen_r[ch_r] || !filter_en_r) begin
          res_nxt   = sample_r;
          state_nxt = ST_WRITE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt   = div_q;
          state_nxt = ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        if (limit_en_r) begin
          if ({1'b0, res_r} > hi_bound) res_nxt = hi_bound[SAMPLE_BITS-1:0];
          else if (lo_test < {1'b0, prev_r}) res_nxt = prev_r - step_r;
        end
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        // hold until the output register is free
        if (out_go) begin
          mem_we         = 1'b1;
          seen_nxt[ch_r] = 1'b1;
          out_valid_nxt  = 1'b1;
          out_chan_nxt   = ch_r;
          out_val_nxt    = res_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    sample_r   <= sample_nxt;
    res_r      <= res_nxt;
    out_chan_r <= out_chan_nxt;
    out_val_r  <= out_val_nxt;
  end

  // channel memory: one read on acceptance, one write at the end
  always_ff @(posedge clk) begin
    if (in_acc && in_range) prev_r <= mem[in_channel];
    if (mem_we) mem[ch_r] <= res_r;
  end

  assign out_valid          = out_valid_r;
  assign out_channel        = out_chan_r;
  assign out_filtered_value = out_val_r;

  a_drop_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_range |=> state_r == ST_IDLE && $stable(seen_r))
    else $error("out-of-range channel changed state");

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_write_loads: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> out_valid_r && seen_r[out_chan_r] && out_val_r == $past(res_r))
    else $error("write-back did not load the output word");

  a_limit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LIMIT && limit_en_r |=>
      ({1'b0, res_r} <= {1'b0, prev_r} + {1'b0, step_r}) &&
      ({1'b0, res_r} + {1'b0, step_r} >= {1'b0, prev_r}))
    else $error("step limit exceeded");

endmodule

@@ hdl/adsf_div.sv @@
// Restoring divider: one quotient bit per cycle.
module adsf_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [adsf_pkg::NUM_W-1:0]         dividend,
  input  logic [adsf_pkg::DIV_W-1:0]         divisor,
  output logic                               done,
  output logic [adsf_pkg::SAMPLE_BITS-1:0]   quotient
);
  import adsf_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] div_r, div_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign ge    = (trial >= {1'b0, div_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      div_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract where it fits
      rem_nxt = ge ? DIV_W'(trial - {1'b0, div_r}) : trial[DIV_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
  end

  // the quotient never exceeds the larger of prev and sample
  assign quotient = quo_r[SAMPLE_BITS-1:0];
  assign done     = done_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a running division");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && cnt_r == CNT_W'(NUM_W))
    else $error("divider did not load on start");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start |=> rem_r < div_r)
    else $error("divider remainder out of range");

endmodule

@@ test/tb_top.sv @@
// Self-checking bench for the per-channel deadband, smoothing and step-limit filter.
module tb_top;
  import adsf_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 32;
  localparam int PHASES       = 10;
  localparam int PHASE_WORDS  = 50;

  typedef struct packed {
    logic [CHAN_W-1:0]      chan;
    logic [SAMPLE_BITS-1:0] value;
  } filt_word_t;

  logic                   clk           = 1'b0;
  logic                   rst_n         = 1'b0;
  logic                   in_valid      = 1'b0;
  logic                   in_ready;
  logic [CHAN_W-1:0]      in_channel    = '0;
  logic [SAMPLE_BITS-1:0] in_raw_sample = '0;
  logic                   out_valid;
  logic                   out_ready     = 1'b0;
  logic [CHAN_W-1:0]      out_channel;
  logic [SAMPLE_BITS-1:0] out_filtered_value;
  logic                   cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index     = '0;
  logic [CFG_W-1:0]       cfg_wdata     = '0;

  // predictor copy of the registers and the channel memory
  logic                   cur_filter_en;
  logic [K_W-1:0]         cur_k;
  logic [SAMPLE_BITS-1:0] cur_deadband;
  logic [SAMPLE_BITS-1:0] cur_step;
  logic                   cur_limit_en;
  logic [SAMPLE_BITS-1:0] chan_value [CHANNELS];
  logic                   chan_seen  [CHANNELS];

  filt_word_t pending_words[$];
  int         err_cnt     = 0;
  int         idle_cycles = 0;
  bit         calm        = 1'b0;

  adc_deadband_smoothing_filter_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_channel         (in_channel),
    .in_raw_sample      (in_raw_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_channel        (out_channel),
    .out_filtered_value (out_filtered_value),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void clear_filter_state();
    cur_filter_en = 1'b1;
    cur_k         = 8'd10;
    cur_deadband  = 12'd12;
    cur_step      = 12'd20;
    cur_limit_en  = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      chan_value[i] = '0;
      chan_seen[i]  = 1'b0;
    end
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] smoothed_value(input logic [SAMPLE_BITS-1:0] prev,
                                                            input logic [SAMPLE_BITS-1:0] raw);
    int unsigned p;
    int unsigned target;
    int unsigned diff;
    int unsigned acc;
    int unsigned kk;
    int unsigned lim;
    p      = 32'(prev);
    target = 32'(raw);
    kk     = 32'(cur_k);
    lim    = 32'(cur_step);
    diff   = (target > p) ? target - p : p - target;
    if (diff < 32'(cur_deadband)) target = p;
    acc = (p * kk + target) / (kk + 1);
    if (cur_limit_en) begin
      if (acc > p + lim) acc = p + lim;
      else if (acc + lim < p) acc = p - lim;
    end
    return acc[SAMPLE_BITS-1:0];
  endfunction

  // advance the predicted channel memory for one accepted word
  function automatic void record_word(input logic [CHAN_W-1:0] ch,
                                      input logic [SAMPLE_BITS-1:0] raw);
    logic [SAMPLE_BITS-1:0] v;
    if (ch >= CHANNELS) return;
    if (!chan_seen[ch]) begin
      v = raw;
      chan_seen[ch] = 1'b1;
    end else if (cur_filter_en) begin
      v = smoothed_value(chan_value[ch], raw);
    end else begin
      v = raw;
    end
    chan_value[ch] = v;
    pending_words.push_back('{chan: ch, value: v});
  endfunction

  task automatic send_word(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_BITS-1:0] raw);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_channel    <= ch;
    in_raw_sample <= raw;
    do @(posedge clk); while (!in_ready);
    record_word(ch, raw);
  endtask

  // hold the sender until every result is in, then let a dropped word settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_FILTER_EN: cur_filter_en = data[0];
      CFG_SMOOTH:    cur_k         = data[K_W-1:0];
      CFG_DEADBAND:  cur_deadband  = data[SAMPLE_BITS-1:0];
      CFG_STEP:      cur_step      = data[SAMPLE_BITS-1:0];
      CFG_LIMIT_EN:  cur_limit_en  = data[0];
      default: ;
    endcase
  endtask

  // upper bits of the narrow registers carry junk that must be dropped
  task automatic set_filter(input logic fe, input logic [K_W-1:0] k,
                            input logic [SAMPLE_BITS-1:0] db, input logic [SAMPLE_BITS-1:0] st,
                            input logic le);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom_range(0, 4095));
    write_reg(CFG_FILTER_EN, {junk[CFG_W-1:1], fe});
    junk = CFG_W'($urandom_range(0, 4095));
    write_reg(CFG_SMOOTH, {junk[CFG_W-1:K_W], k});
    write_reg(CFG_DEADBAND, db);
    write_reg(CFG_STEP, st);
    junk = CFG_W'($urandom_range(0, 4095));
    write_reg(CFG_LIMIT_EN, {junk[CFG_W-1:1], le});
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [CHAN_W-1:0] ch);
    int base;
    int off;
    int s;
    base = (ch < CHANNELS) ? int'(chan_value[ch]) : 2048;
    case ($urandom_range(0, 9))
      0:       s = 0;
      1:       s = 4095;
      2, 3:    s = $urandom_range(0, 4095);
      default: begin
        // aim at the deadband and step-limit edges around the stored value
        case ($urandom_range(0, 4))
          0:       off = int'(cur_deadband);
          1:       off = int'(cur_deadband) - 1;
          2:       off = int'(cur_deadband) + 1;
          3:       off = int'(cur_step) + $urandom_range(0, 3);
          default: off = $urandom_range(0, 60);
        endcase
        s = $urandom_range(0, 1) ? base + off : base - off;
        if (s < 0) s = 0;
        if (s > 4095) s = 4095;
      end
    endcase
    return s[SAMPLE_BITS-1:0];
  endfunction

  task automatic test_first_samples();
    send_word(3'd0, 12'd0);
    send_word(3'd1, 12'd4095);
    send_word(3'd2, 12'hAAA);
    send_word(3'd6, 12'hFFF);
    send_word(3'd3, 12'h555);
    send_word(3'd7, 12'd0);
    send_word(3'd4, 12'd2048);
    send_word(3'd5, 12'd1);
  endtask

  task automatic test_default_filter();
    send_word(3'd0, 12'd11);
    send_word(3'd0, 12'd12);
    send_word(3'd1, 12'd0);
    drain();
  endtask

  task automatic test_passthrough();
    set_filter(1'b0, 8'd10, 12'd12, 12'd20, 1'b0);
    send_word(3'd2, 12'd0);
    send_word(3'd2, 12'd4095);
    send_word(3'd3, 12'd4094);
    drain();
  endtask

  task automatic test_edge_settings();
    // no smoothing and no deadband
    set_filter(1'b1, 8'd0, 12'd0, 12'd20, 1'b0);
    send_word(3'd4, 12'd7);
    drain();
    // widest deadband holds every change below full scale
    set_filter(1'b1, 8'd255, 12'd4095, 12'd4095, 1'b1);
    send_word(3'd4, 12'd4095);
    send_word(3'd5, 12'd4095);
    drain();
    // zero step with limiting freezes the value
    set_filter(1'b1, 8'd255, 12'd0, 12'd0, 1'b1);
    send_word(3'd0, 12'd4095);
    drain();
    set_filter(1'b1, 8'd0, 12'd0, 12'd4095, 1'b1);
    send_word(3'd1, 12'd0);
    drain();
    // clamp downward, then move upward within the step
    set_filter(1'b1, 8'd1, 12'd0, 12'd5, 1'b1);
    send_word(3'd3, 12'd0);
    send_word(3'd3, 12'd4095);
    drain();
  endtask

  task automatic test_random_streams();
    logic                   fe;
    logic                   le;
    logic [K_W-1:0]         k;
    logic [SAMPLE_BITS-1:0] db;
    logic [SAMPLE_BITS-1:0] st;
    logic [CHAN_W-1:0]      ch;
    int                     sent;
    for (int ph = 0; ph < PHASES; ph++) begin
      fe = ($urandom_range(0, 4) != 0);
      le = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0:       k = 8'd0;
        1:       k = 8'd255;
        2:       k = K_W'($urandom_range(1, 15));
        default: k = K_W'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 3))
        0:       db = 12'd0;
        1:       db = 12'd4095;
        default: db = SAMPLE_BITS'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 3))
        0:       st = 12'd0;
        1:       st = 12'd4095;
        default: st = SAMPLE_BITS'($urandom_range(1, 100));
      endcase
      if (ph == 0) begin
        fe = 1'b1; k = 8'd0; db = 12'd0; st = 12'd4095; le = 1'b1;
      end else if (ph == 1) begin
        fe = 1'b1; k = 8'd255; db = 12'd1; st = 12'd1; le = 1'b1;
      end
      if (ph == PHASES - 1) calm = 1'b1;
      set_filter(fe, k, db, st, le);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        ch = ($urandom_range(0, 19) == 0) ? CHAN_W'($urandom_range(CHANNELS, 7))
                                          : CHAN_W'($urandom_range(0, CHANNELS - 1));
        send_word(ch, pick_sample(ch));
        if (ch < CHANNELS) sent++;
      end
      drain();
    end
  endtask

  initial begin
    clear_filter_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_samples();
    test_default_filter();
    test_passthrough();
    test_edge_settings();
    test_random_streams();
    drain();
    if (err_cnt == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side back-pressure in bursts
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    filt_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected word: expected none, actual ch %0d value %0d",
                 $time, out_channel, out_filtered_value);
      end else begin
        want = pending_words.pop_front();
        if (want.chan !== out_channel) begin
          err_cnt++;
          $display("%0t: channel mismatch: expected %0d, actual %0d",
                   $time, want.chan, out_channel);
        end
        if (want.value !== out_filtered_value) begin
          err_cnt++;
          $display("%0t: value mismatch on ch %0d: expected %0d, actual %0d",
                   $time, want.chan, want.value, out_filtered_value);
        end
      end
    end
  end

  // drop the run if no word moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

@@ sim.f @@
hdl/adsf_pkg.sv
hdl/adsf_div.sv
hdl/adc_deadband_smoothing_filter_unit.sv
test/tb_top.sv
